// ===== src/dpu_pkg.sv =====
package dpu_pkg;

  // Field widths.
  localparam int unsigned PIX_W      = 12;
  localparam int unsigned DEPTH_IN_W = 16;
  localparam int unsigned CONF_W     = 8;
  localparam int unsigned CENTER_W   = 20;
  localparam int unsigned INV_W      = 28;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned Z_W        = 15;
  localparam int unsigned FRAC_W     = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 28;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_CONF = 3'd0,
    CFG_CENTER_X = 3'd1,
    CFG_CENTER_Y = 3'd2,
    CFG_INV_FX   = 3'd3,
    CFG_INV_FY   = 3'd4
  } cfg_idx_e;

  // Image bound and depth window.
  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned DIM_CMP_W = 17;
  localparam int unsigned DEPTH_MIN = 100;
  localparam int unsigned DEPTH_MAX = 10000;

  // A valid depth never needs more than this many bits.
  localparam int unsigned DEPTH_W = 14;

  // Datapath widths: offset * depth, then times the Q4.24 reciprocal.
  localparam int unsigned P1_W  = CENTER_W + DEPTH_W;
  localparam int unsigned P2_W  = P1_W + INV_W;
  localparam int unsigned RND_W = P2_W + 1;
  localparam int unsigned SHR_W = 24;
  localparam int unsigned RES_W = RND_W - SHR_W;

  localparam logic [P2_W-1:0]  ROUND_HALF = P2_W'(64'd1 << (SHR_W - 1));
  localparam logic [OUT_W-1:0] POS_MAX    = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] NEG_MAG    = 32'h8000_0000;

  // Pipeline: front checks, offset*depth, times reciprocal, round/saturate.
  localparam int unsigned NUM_STAGES = 4;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } stage_en_t;

  typedef struct packed {
    logic [CONF_W-1:0]   min_conf;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [INV_W-1:0]    inv_fx;
    logic [INV_W-1:0]    inv_fy;
  } cfg_t;

endpackage

// ===== src/dpu_pix_if.sv =====
interface dpu_pix_if;
  logic                              valid;
  logic                              ready;
  logic [dpu_pkg::PIX_W-1:0]         column;
  logic [dpu_pkg::PIX_W-1:0]         row;
  logic [dpu_pkg::DEPTH_IN_W-1:0]    depth_mm;
  logic [dpu_pkg::CONF_W-1:0]        confidence;

  modport source (output valid, column, row, depth_mm, confidence, input ready);
  modport sink   (input valid, column, row, depth_mm, confidence, output ready);
endinterface

// ===== src/dpu_point_if.sv =====
interface dpu_point_if;
  logic                              valid;
  logic                              ready;
  logic signed [dpu_pkg::OUT_W-1:0]  point_x;
  logic signed [dpu_pkg::OUT_W-1:0]  point_y;
  logic signed [dpu_pkg::Z_W-1:0]    point_z;
  logic                              valid_res;
  logic                              saturated;

  modport source (output valid, point_x, point_y, point_z, valid_res, saturated,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, valid_res, saturated,
                  output ready);
endinterface

// ===== src/dpu_cfg_regs.sv =====
module dpu_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dpu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dpu_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output dpu_pkg::cfg_t                    cfg_o
);

  dpu_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dpu_pkg::CFG_MIN_CONF: cfg_d.min_conf = cfg_wdata_i[dpu_pkg::CONF_W-1:0];
        dpu_pkg::CFG_CENTER_X: cfg_d.center_x = cfg_wdata_i[dpu_pkg::CENTER_W-1:0];
        dpu_pkg::CFG_CENTER_Y: cfg_d.center_y = cfg_wdata_i[dpu_pkg::CENTER_W-1:0];
        dpu_pkg::CFG_INV_FX:   cfg_d.inv_fx   = cfg_wdata_i[dpu_pkg::INV_W-1:0];
        dpu_pkg::CFG_INV_FY:   cfg_d.inv_fy   = cfg_wdata_i[dpu_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/dpu_pipe_ctrl.sv =====
module dpu_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dpu_pkg::stage_en_t  en_o
);

  logic [dpu_pkg::NUM_STAGES-1:0] valid_d, valid_q;
  logic [dpu_pkg::NUM_STAGES-1:0] rdy;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    rdy[dpu_pkg::NUM_STAGES-1] = !valid_q[dpu_pkg::NUM_STAGES-1] || out_ready_i;
    for (int k = dpu_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (rdy[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < dpu_pkg::NUM_STAGES; k++) begin
      if (rdy[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign en_o.load   = rdy;
  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[dpu_pkg::NUM_STAGES-1];

endmodule

// ===== src/dpu_axis.sv =====
module dpu_axis (
  input  logic                              clk_i,
  input  dpu_pkg::stage_en_t                en_i,
  input  logic [dpu_pkg::PIX_W-1:0]         pix_i,
  input  logic [dpu_pkg::DEPTH_W-1:0]       depth_i,
  input  logic                              ok_i,
  input  logic                              flip_i,
  input  logic [dpu_pkg::CENTER_W-1:0]      center_i,
  input  logic [dpu_pkg::INV_W-1:0]         inv_i,
  output logic signed [dpu_pkg::OUT_W-1:0]  value_o,
  output logic                              sat_o
);

  logic [dpu_pkg::CENTER_W-1:0] pq;
  logic [dpu_pkg::CENTER_W-1:0] mag_d, mag_q;
  logic                         minus_d;
  logic                         minus1_q, minus2_q, minus3_q;
  logic [dpu_pkg::DEPTH_W-1:0]  depth_q;
  logic [dpu_pkg::P1_W-1:0]     p1_d, p1_q;
  logic [dpu_pkg::P2_W-1:0]     p2_d, p2_q;
  logic [dpu_pkg::RND_W-1:0]    rnd;
  logic [dpu_pkg::RES_W-1:0]    res;
  logic [dpu_pkg::OUT_W-1:0]    neg_mag;
  logic [dpu_pkg::OUT_W-1:0]    value_d, value_q;
  logic                         sat_d, sat_q;

  // Pixel index in Q.8, then the magnitude and sign of its offset.
  assign pq = {pix_i, dpu_pkg::FRAC_W'(0)};

  // An invalid pixel gets a zero offset, so its coordinate and flag come out zero.
  always_comb begin
    if (pq >= center_i) begin
      mag_d   = pq - center_i;
      minus_d = flip_i;
    end else begin
      mag_d   = center_i - pq;
      minus_d = !flip_i;
    end
    if (!ok_i) begin
      mag_d = '0;
    end
  end

  assign p1_d = dpu_pkg::P1_W'(mag_q) * dpu_pkg::P1_W'(depth_q);
  assign p2_d = dpu_pkg::P2_W'(p1_q) * dpu_pkg::P2_W'(inv_i);

  // Q.32 to Q.8, rounding the magnitude half away from zero.
  assign rnd = dpu_pkg::RND_W'(p2_q) + dpu_pkg::RND_W'(dpu_pkg::ROUND_HALF);
  assign res = rnd[dpu_pkg::RND_W-1:dpu_pkg::SHR_W];

  always_comb begin
    sat_d   = 1'b0;
    neg_mag = '0;
    if (!minus3_q) begin
      if (res > dpu_pkg::RES_W'(dpu_pkg::POS_MAX)) begin
        sat_d   = 1'b1;
        value_d = dpu_pkg::POS_MAX;
      end else begin
        value_d = res[dpu_pkg::OUT_W-1:0];
      end
    end else begin
      if (res > dpu_pkg::RES_W'(dpu_pkg::NEG_MAG)) begin
        sat_d   = 1'b1;
        neg_mag = dpu_pkg::NEG_MAG;
      end else begin
        neg_mag = res[dpu_pkg::OUT_W-1:0];
      end
      value_d = dpu_pkg::OUT_W'(0) - neg_mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.load[0]) begin
      mag_q    <= mag_d;
      minus1_q <= minus_d;
      depth_q  <= depth_i;
    end
    if (en_i.load[1]) begin
      p1_q     <= p1_d;
      minus2_q <= minus1_q;
    end
    if (en_i.load[2]) begin
      p2_q     <= p2_d;
      minus3_q <= minus2_q;
    end
    if (en_i.load[3]) begin
      value_q  <= value_d;
      sat_q    <= sat_d;
    end
  end

  assign value_o = value_q;
  assign sat_o   = sat_q;

endmodule

// ===== src/depth_pixel_unproject_top.sv =====
// Channel  | Port     | Direction | Payload
// ---------+----------+-----------+----------------------------------------------
// pixel    | pix_i    | in        | column, row, depth_mm, confidence
// point    | point_o  | out       | point_x, point_y, point_z, valid_res, saturated
// config   | cfg_*_i  | in        | cfg_idx_i selects the register, cfg_wdata_i
//
// One pixel per clock while point_o is ready; each result is offered after
// its transaction passes four pipeline registers: range checks, offset
// times depth, product times reciprocal, rounding and saturation.
// Reset clears the stage valid bits and the configuration registers.
// A stall holds only the full stages; empty stages ahead of it keep filling.
module depth_pixel_unproject_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dpu_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  dpu_pix_if.sink                         pix_i,
  dpu_point_if.source                     point_o
);

  dpu_pkg::cfg_t      cfg;
  dpu_pkg::stage_en_t en;

  logic                          ok_d;
  logic [dpu_pkg::Z_W-1:0]       z_d;
  logic [dpu_pkg::DEPTH_W-1:0]   depth;
  logic                          ok_q [dpu_pkg::NUM_STAGES];
  logic [dpu_pkg::Z_W-1:0]       z_q  [dpu_pkg::NUM_STAGES];
  logic signed [dpu_pkg::OUT_W-1:0] x_val, y_val;
  logic                          x_sat, y_sat;

  dpu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dpu_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (point_o.valid),
    .out_ready_i (point_o.ready),
    .en_o        (en)
  );

  assign ok_d = (pix_i.depth_mm >= dpu_pkg::DEPTH_IN_W'(dpu_pkg::DEPTH_MIN))
             && (pix_i.depth_mm <= dpu_pkg::DEPTH_IN_W'(dpu_pkg::DEPTH_MAX))
             && (pix_i.confidence >= cfg.min_conf)
             && (dpu_pkg::DIM_CMP_W'(pix_i.column) < dpu_pkg::DIM_CMP_W'(dpu_pkg::MAX_DIM))
             && (dpu_pkg::DIM_CMP_W'(pix_i.row) < dpu_pkg::DIM_CMP_W'(dpu_pkg::MAX_DIM));

  // Only a depth inside the window is used, and that fits in DEPTH_W bits.
  assign depth = pix_i.depth_mm[dpu_pkg::DEPTH_W-1:0];
  assign z_d   = ok_d ? (dpu_pkg::Z_W'(0) - pix_i.depth_mm[dpu_pkg::Z_W-1:0]) : '0;

  always_ff @(posedge clk_i) begin
    if (en.load[0]) begin
      ok_q[0] <= ok_d;
      z_q[0]  <= z_d;
    end
    for (int k = 1; k < dpu_pkg::NUM_STAGES; k++) begin
      if (en.load[k]) begin
        ok_q[k] <= ok_q[k-1];
        z_q[k]  <= z_q[k-1];
      end
    end
  end

  dpu_axis u_axis_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .pix_i    (pix_i.column),
    .depth_i  (depth),
    .ok_i     (ok_d),
    .flip_i   (1'b0),
    .center_i (cfg.center_x),
    .inv_i    (cfg.inv_fx),
    .value_o  (x_val),
    .sat_o    (x_sat)
  );

  // The y axis points up, so its sign is flipped against the row offset.
  dpu_axis u_axis_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .pix_i    (pix_i.row),
    .depth_i  (depth),
    .ok_i     (ok_d),
    .flip_i   (1'b1),
    .center_i (cfg.center_y),
    .inv_i    (cfg.inv_fy),
    .value_o  (y_val),
    .sat_o    (y_sat)
  );

  assign point_o.point_x   = x_val;
  assign point_o.point_y   = y_val;
  assign point_o.point_z   = z_q[dpu_pkg::NUM_STAGES-1];
  assign point_o.valid_res = ok_q[dpu_pkg::NUM_STAGES-1];
  assign point_o.saturated = x_sat | y_sat;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import dpu_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int PIPE_DRAIN  = 8;
  localparam int HOLD_CYCLES = 80;

  // No register sits at this index, so a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0]      column;
    logic [PIX_W-1:0]      row;
    logic [DEPTH_IN_W-1:0] depth_mm;
    logic [CONF_W-1:0]     confidence;
  } pixel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic signed [Z_W-1:0]   point_z;
    logic                    valid_res;
    logic                    saturated;
  } point_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  dpu_pix_if   pix_if ();
  dpu_point_if point_if ();

  depth_pixel_unproject_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_if),
    .point_o     (point_if)
  );

  cfg_t   cfg_shadow;
  pixel_t pixel_backlog[$];
  pixel_t staged_pixels[$];
  point_t predicted_points[$];

  bit pixel_taken;
  bit sink_hold;
  bit holdoff_req;
  int src_gap;
  int snk_gap;
  int src_idle_pct;
  int snk_idle_pct;
  int pixels_queued;
  int points_seen;
  int valid_count;
  int sat_count;
  int settings_run;
  int mismatches;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // One axis of the unprojection: Q.8 offset from the principal point, times
  // depth, times the Q4.24 reciprocal, rounded on the magnitude to Q.8.
  function automatic logic [OUT_W-1:0] scale_axis(input logic [PIX_W-1:0] pix,
                                                  input logic [CENTER_W-1:0] ctr,
                                                  input logic [DEPTH_IN_W-1:0] depth,
                                                  input logic [INV_W-1:0] inv,
                                                  input bit flip, inout bit clamp);
    logic [63:0] pix_q8;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] mag_q8;
    bit          minus;
    pix_q8 = {44'd0, pix, 8'd0};
    if (pix_q8 >= ctr) begin
      mag   = pix_q8 - ctr;
      minus = 1'b0;
    end else begin
      mag   = ctr - pix_q8;
      minus = 1'b1;
    end
    minus  = minus ^ flip;
    prod   = mag * depth * inv;
    mag_q8 = (prod + (64'd1 << 23)) >> 24;
    if (mag_q8 == 0) return '0;
    if (!minus) begin
      if (mag_q8 > 64'h7FFF_FFFF) begin
        clamp  = 1'b1;
        mag_q8 = 64'h7FFF_FFFF;
      end
      return mag_q8[OUT_W-1:0];
    end
    if (mag_q8 > 64'h8000_0000) begin
      clamp  = 1'b1;
      mag_q8 = 64'h8000_0000;
    end
    mag_q8 = 64'd0 - mag_q8;
    return mag_q8[OUT_W-1:0];
  endfunction

  function automatic point_t unproject_pixel(input pixel_t px);
    point_t                pt;
    bit                    clamp;
    logic [DEPTH_IN_W-1:0] neg_depth;
    pt    = '0;
    clamp = 1'b0;
    if (px.depth_mm >= DEPTH_MIN && px.depth_mm <= DEPTH_MAX &&
        px.confidence >= cfg_shadow.min_conf &&
        px.column < MAX_DIM && px.row < MAX_DIM) begin
      pt.point_x   = scale_axis(px.column, cfg_shadow.center_x, px.depth_mm,
                                cfg_shadow.inv_fx, 1'b0, clamp);
      pt.point_y   = scale_axis(px.row, cfg_shadow.center_y, px.depth_mm,
                                cfg_shadow.inv_fy, 1'b1, clamp);
      neg_depth    = 16'd0 - px.depth_mm;
      pt.point_z   = neg_depth[Z_W-1:0];
      pt.valid_res = 1'b1;
      pt.saturated = clamp;
    end
    return pt;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.column = PIX_W'($urandom_range(0, MAX_DIM - 1));
    px.row    = PIX_W'($urandom_range(0, MAX_DIM - 1));
    case ($urandom_range(9))
      0: px.depth_mm = DEPTH_IN_W'($urandom);
      1: px.depth_mm = DEPTH_IN_W'($urandom_range(0, DEPTH_MIN + 20));
      2: px.depth_mm = DEPTH_IN_W'($urandom_range(DEPTH_MAX - 20, DEPTH_MAX + 20));
      default: px.depth_mm = DEPTH_IN_W'($urandom_range(DEPTH_MIN, DEPTH_MAX));
    endcase
    // A quarter of the pixels sit right at the confidence threshold or just below it.
    if ($urandom_range(3) == 0)
      px.confidence = cfg_shadow.min_conf - CONF_W'($urandom_range(1));
    else
      px.confidence = CONF_W'($urandom);
    return px;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_inv_focal();
    case ($urandom_range(4))
      0: return CFG_DATA_W'($urandom);
      1: return '0;
      default: return CFG_DATA_W'((32'd1 << 24) / $urandom_range(100, 2000));
    endcase
  endfunction

  task automatic stage_pixel(input int col, input int row, input int depth, input int conf);
    pixel_t px;
    px.column     = PIX_W'(col);
    px.row        = PIX_W'(row);
    px.depth_mm   = DEPTH_IN_W'(depth);
    px.confidence = CONF_W'(conf);
    staged_pixels.push_back(px);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_MIN_CONF: cfg_shadow.min_conf = data[CONF_W-1:0];
      CFG_CENTER_X: cfg_shadow.center_x = data[CENTER_W-1:0];
      CFG_CENTER_Y: cfg_shadow.center_y = data[CENTER_W-1:0];
      CFG_INV_FX:   cfg_shadow.inv_fx   = data[INV_W-1:0];
      CFG_INV_FY:   cfg_shadow.inv_fy   = data[INV_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_config();
    if ($urandom_range(3) == 0)
      write_reg(CFG_MIN_CONF, '0);
    else
      write_reg(CFG_MIN_CONF, CFG_DATA_W'($urandom));
    write_reg(CFG_CENTER_X, CFG_DATA_W'($urandom_range(0, 20'hF_FFFF)));
    write_reg(CFG_CENTER_Y, CFG_DATA_W'($urandom_range(0, 20'hF_FFFF)));
    write_reg(CFG_INV_FX, random_inv_focal());
    write_reg(CFG_INV_FY, random_inv_focal());
    write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
  endtask

  // Hands the staged and random pixels to the driver, then waits until every
  // point has come back so that the registers can be rewritten safely.
  task automatic run_phase(input int n_random, input int src_pct, input int snk_pct,
                           input bit holdoff);
    @(posedge clk_i);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    if (holdoff) holdoff_req = 1'b1;
    while (staged_pixels.size() != 0) pixel_backlog.push_back(staged_pixels.pop_front());
    repeat (n_random) pixel_backlog.push_back(random_pixel());
    pixels_queued += pixel_backlog.size();
    settings_run++;
    do @(negedge clk_i); while (points_seen < pixels_queued);
    repeat (PIPE_DRAIN) @(negedge clk_i);
  endtask

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(negedge clk_i) begin : pixel_driver
    pixel_t px;
    if (pixel_taken || !pix_if.valid) begin
      if (src_gap == 0 && pixel_backlog.size() != 0 && src_idle_pct != 0 &&
          $urandom_range(99) < src_idle_pct)
        src_gap = $urandom_range(1, 14);
      if (src_gap != 0) begin
        src_gap--;
        pix_if.valid <= 1'b0;
      end else if (pixel_backlog.size() != 0) begin
        px = pixel_backlog.pop_front();
        pix_if.valid      <= 1'b1;
        pix_if.column     <= px.column;
        pix_if.row        <= px.row;
        pix_if.depth_mm   <= px.depth_mm;
        pix_if.confidence <= px.confidence;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : point_sink
    logic ready_n;
    if (sink_hold) begin
      ready_n = 1'b0;
    end else begin
      if (snk_gap == 0 && snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct)
        snk_gap = $urandom_range(1, 14);
      if (snk_gap != 0) begin
        snk_gap--;
        ready_n = 1'b0;
      end else begin
        ready_n = 1'b1;
      end
    end
    point_if.ready <= ready_n;
  end

  initial begin : sink_holdoff
    wait (holdoff_req);
    @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  always @(posedge clk_i) begin : point_monitor
    pixel_t px;
    point_t want;
    point_t got;
    pixel_taken = rst_ni && pix_if.valid && pix_if.ready;
    if (pixel_taken) begin
      px.column     = pix_if.column;
      px.row        = pix_if.row;
      px.depth_mm   = pix_if.depth_mm;
      px.confidence = pix_if.confidence;
      want = unproject_pixel(px);
      if (want.valid_res) valid_count++;
      if (want.saturated) sat_count++;
      predicted_points.push_back(want);
    end
    if (rst_ni && point_if.valid && point_if.ready) begin
      points_seen++;
      got.point_x   = point_if.point_x;
      got.point_y   = point_if.point_y;
      got.point_z   = point_if.point_z;
      got.valid_res = point_if.valid_res;
      got.saturated = point_if.saturated;
      if (predicted_points.size() == 0) begin
        mismatches++;
        $display("%0t: point with no pixel pending, expected none, actual x=%0d y=%0d z=%0d",
                 $time, got.point_x, got.point_y, got.point_z);
      end else begin
        want = predicted_points.pop_front();
        check_field("point_x", $signed(want.point_x), $signed(got.point_x));
        check_field("point_y", $signed(want.point_y), $signed(got.point_y));
        check_field("point_z", $signed(want.point_z), $signed(got.point_z));
        check_field("valid_res", want.valid_res, got.valid_res);
        check_field("saturated", want.saturated, got.saturated);
      end
    end
  end

  initial begin : watchdog
    #(CLK_PERIOD * 300000);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_MIN_CONF;
    cfg_wdata_i       = '0;
    pix_if.valid      = 1'b0;
    pix_if.column     = '0;
    pix_if.row        = '0;
    pix_if.depth_mm   = '0;
    pix_if.confidence = '0;
    point_if.ready    = 1'b0;
    cfg_shadow        = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers at reset: zero reciprocals give zero x and y for valid pixels.
    stage_pixel(0, 0, DEPTH_MIN, 0);
    stage_pixel(4095, 4095, DEPTH_MAX, 255);
    stage_pixel(2048, 1000, DEPTH_MIN - 1, 0);
    stage_pixel(100, 100, DEPTH_MAX + 1, 128);
    run_phase(50, 20, 20, 1'b0);

    // A VGA-like camera with a focal length of about 525 pixels.
    write_reg(CFG_MIN_CONF, 28'd128);
    write_reg(CFG_CENTER_X, 28'd320 << 8);
    write_reg(CFG_CENTER_Y, 28'd240 << 8);
    write_reg(CFG_INV_FX, 28'd31957);
    write_reg(CFG_INV_FY, 28'd31957);
    write_reg(CFG_UNUSED_IDX, 28'hFFF_FFFF);
    stage_pixel(320, 240, 1000, 200);
    stage_pixel(0, 0, 0, 255);
    stage_pixel(4095, 4095, 65535, 255);
    stage_pixel(639, 479, 5000, 128);
    stage_pixel(10, 10, 5000, 127);
    stage_pixel(700, 20, DEPTH_MAX, 255);
    stage_pixel(320, 241, DEPTH_MIN, 128);
    run_phase(300, 15, 15, 1'b0);

    // Largest reciprocals with the center in opposite corners: clamps upward.
    write_reg(CFG_MIN_CONF, 28'd255);
    write_reg(CFG_CENTER_X, '0);
    write_reg(CFG_CENTER_Y, 28'hF_FFFF);
    write_reg(CFG_INV_FX, 28'hFFF_FFFF);
    write_reg(CFG_INV_FY, 28'hFFF_FFFF);
    stage_pixel(4095, 0, DEPTH_MAX, 255);
    stage_pixel(0, 4095, DEPTH_MIN, 255);
    stage_pixel(2000, 2000, 5000, 254);
    run_phase(150, 0, 25, 1'b0);

    // Center moved to the other corners: clamps downward.
    write_reg(CFG_MIN_CONF, '0);
    write_reg(CFG_CENTER_X, 28'hF_FFFF);
    write_reg(CFG_CENTER_Y, '0);
    stage_pixel(0, 4095, DEPTH_MAX, 0);
    stage_pixel(4095, 0, DEPTH_MIN, 0);
    run_phase(150, 25, 0, 1'b0);

    repeat (3) begin
      random_config();
      run_phase(200, 15, 15, 1'b0);
    end

    // The sender streams without a break while the receiver stops for a while,
    // so the pipeline fills and has to back-pressure the pixel channel.
    random_config();
    run_phase(200, 0, 0, 1'b1);

    random_config();
    run_phase(200, 0, 0, 1'b0);

    repeat (PIPE_DRAIN * 2) @(negedge clk_i);
    if (predicted_points.size() != 0) begin
      mismatches++;
      $display("%0t: %0d predicted points, expected to arrive, actual none",
               $time, predicted_points.size());
    end
    $display("summary: %0d pixels unprojected across %0d register settings",
             points_seen, settings_run);
    $display("summary: %0d valid points, %0d of them clamped; %0d mismatches",
             valid_count, sat_count, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
